// ===== rtl/scla_pkg.sv =====
// shared types and constants of the scrolling comment lane allocator
package scla_pkg;

	localparam int SCREEN_W = 14;
	localparam int TIME_W   = 16;
	localparam int SCALE_W  = 16;
	localparam int ACTIVE_W = 7;
	localparam int CFG_W    = 16;
	localparam int START_W  = 32;
	localparam int CHARS_W  = 10;
	localparam int FONT_W   = 8;
	localparam int LANE_W   = 6;
	localparam int SCALED_W = 16;
	localparam int LEN_W    = 26;
	localparam int SUM_W    = 27;
	localparam int TL_W     = TIME_W + LEN_W;
	localparam int DS_W     = START_W + SUM_W;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH = 2'd0,
		REG_SCROLL_TIME  = 2'd1,
		REG_FONT_SCALE   = 2'd2,
		REG_ACTIVE_LANES = 2'd3
	} cfg_reg_t;

	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST = SCREEN_W'(1920);
	localparam logic [TIME_W-1:0]   SCROLL_TIME_RST  = TIME_W'(8000);
	localparam logic [SCALE_W-1:0]  FONT_SCALE_RST   = SCALE_W'(256);
	localparam logic [ACTIVE_W-1:0] ACTIVE_LANES_RST = ACTIVE_W'(16);

endpackage

// ===== rtl/scla_ram.sv =====
// generic simple dual-port ram with registered read
module scla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/scroll_comment_lane_allocator.sv =====
// scrolling comment lane allocator: lane scan over a start/length ram
// an input beat passes through the states prep1, prep2, prep3 and a lane scan to done, which
// registers the result onto the output; lanes are read one per cycle into a 3-stage compare
// comments are taken one at a time: in_stall stays high from the input beat until the result
// has been registered onto the output
// reset: config registers take their defaults, all lane busy bits clear at once
module scroll_comment_lane_allocator
	import scla_pkg::*;
#(
	parameter int MAX_LANES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                start_of_list,
	input  logic [START_W-1:0]  start_ms,
	input  logic [CHARS_W-1:0]  char_count,
	input  logic [FONT_W-1:0]   font_pt,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                placed,
	output logic [LANE_W-1:0]   lane
);

	localparam int LW    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int CNT_W = LW + 1;
	localparam int RAM_W = START_W + LEN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_PREP3,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [SCREEN_W-1:0] screen_width_q;
	logic [TIME_W-1:0]   scroll_time_q;
	logic [SCALE_W-1:0]  font_scale_q;
	logic [ACTIVE_W-1:0] active_lanes_q;

	logic [START_W-1:0]  start_q;
	logic [CHARS_W-1:0]  chars_q;
	logic [FONT_W-1:0]   font_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [LEN_W-1:0]    new_len_q;
	logic [SUM_W-1:0]    wn_q;
	logic [TL_W-1:0]     tn_q;

	logic [MAX_LANES-1:0] busy_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     lanes;
	logic [SCREEN_W-1:0]  weff;

	logic            v_s1, v_s2, v_s3;
	logic [LW-1:0]   lane_s1, lane_s2, lane_s3;
	logic            busy_s2, busy_s3;
	logic            neg_s2, neg_s3;
	logic [START_W-1:0] d_s2;
	logic [SUM_W-1:0]   wl_s2;
	logic [LEN_W-1:0]   l_s2;
	logic [DS_W-1:0]    p1_s3, p3_s3;
	logic [TL_W-1:0]    p2_s3;

	logic               issue;
	logic               hit;
	logic               mem_we;
	logic [RAM_W-1:0]   rdata;
	logic [START_W-1:0] rd_start;
	logic [LEN_W-1:0]   rd_len;
	logic [FONT_W+SCALE_W-1:0] scale_prod;
	logic [LEN_W-1:0]   len_prod;

	logic            out_valid_q;
	logic            placed_q;
	logic [LW-1:0]   lane_q;
	logic            res_placed_q;
	logic [LW-1:0]   res_lane_q;

	assign weff = (screen_width_q == '0) ? SCREEN_W'(1) : screen_width_q;

	always_comb begin
		if (int'(active_lanes_q) > MAX_LANES) begin
			lanes = CNT_W'(MAX_LANES);
		end else begin
			lanes = CNT_W'(active_lanes_q);
		end
	end

	assign scale_prod = font_q * font_scale_q;
	assign len_prod   = chars_q * scaled_q;
	assign {rd_start, rd_len} = rdata;

	assign hit = v_s3 && (!busy_s3 || (!neg_s3 && (p1_s3 >= DS_W'(p2_s3))
		&& (p3_s3 >= DS_W'(tn_q))));
	assign issue  = (state_q == ST_SCAN) && !hit && (idx_q < lanes);
	assign mem_we = (state_q == ST_SCAN) && hit;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign placed    = placed_q;
	assign lane      = LANE_W'(lane_q);

	scla_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_LANES)
	) u_lane_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(lane_s3),
		.wdata({start_q, new_len_q}),
		.raddr(idx_q[LW-1:0]),
		.rdata(rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			scroll_time_q  <= SCROLL_TIME_RST;
			font_scale_q   <= FONT_SCALE_RST;
			active_lanes_q <= ACTIVE_LANES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data[SCREEN_W-1:0];
				REG_SCROLL_TIME:  scroll_time_q  <= cfg_data[TIME_W-1:0];
				REG_FONT_SCALE:   font_scale_q   <= cfg_data[SCALE_W-1:0];
				REG_ACTIVE_LANES: active_lanes_q <= cfg_data[ACTIVE_W-1:0];
				default: ;
			endcase
		end
	end

	// control and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= '0;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			out_valid_q  <= 1'b0;
			placed_q     <= 1'b0;
			lane_q       <= '0;
			res_placed_q <= 1'b0;
			res_lane_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (start_of_list) begin
							busy_q <= '0;
						end
						state_q <= ST_PREP1;
					end
				end
				ST_PREP1: state_q <= ST_PREP2;
				ST_PREP2: state_q <= ST_PREP3;
				ST_PREP3: begin
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit) begin
						busy_q[lane_s3] <= 1'b1;
						res_placed_q    <= 1'b1;
						res_lane_q      <= lane_s3;
						v_s1            <= 1'b0;
						v_s2            <= 1'b0;
						v_s3            <= 1'b0;
						state_q         <= ST_DONE;
					end else begin
						v_s1 <= issue;
						v_s2 <= v_s1;
						v_s3 <= v_s2;
						if (issue) begin
							idx_q <= idx_q + CNT_W'(1);
						end else if (!v_s1 && !v_s2 && !v_s3) begin
							res_placed_q <= 1'b0;
							res_lane_q   <= '0;
							state_q      <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						placed_q    <= res_placed_q;
						lane_q      <= res_lane_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item data and compare pipeline
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			start_q <= start_ms;
			chars_q <= char_count;
			font_q  <= font_pt;
		end
		scaled_q  <= scale_prod[FONT_W+SCALE_W-1:8];
		new_len_q <= (state_q == ST_PREP2) ? len_prod : new_len_q;
		wn_q      <= SUM_W'(weff) + SUM_W'(new_len_q);
		tn_q      <= scroll_time_q * new_len_q;

		lane_s1 <= idx_q[LW-1:0];

		lane_s2 <= lane_s1;
		busy_s2 <= busy_q[lane_s1];
		neg_s2  <= (start_q < rd_start);
		d_s2    <= start_q - rd_start;
		wl_s2   <= SUM_W'(weff) + SUM_W'(rd_len);
		l_s2    <= rd_len;

		lane_s3 <= lane_s2;
		busy_s3 <= busy_s2;
		neg_s3  <= neg_s2;
		p1_s3   <= d_s2 * wl_s2;
		p2_s3   <= scroll_time_q * l_s2;
		p3_s3   <= d_s2 * wn_q;
	end

`ifndef SYNTHESIS
	a_lane_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_placed_q) |-> (CNT_W'(res_lane_q) < lanes))
		else $error("placed lane beyond active lanes");

	a_drop_lane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !res_placed_q) |-> (res_lane_q == '0))
		else $error("dropped comment with nonzero lane");

	a_write_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> busy_q[$past(lane_s3)])
		else $error("written lane not marked busy");

	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> !(v_s1 || v_s2 || v_s3))
		else $error("compare pipeline active outside scan");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("result left done state while output beat stalled");
`endif

endmodule
